// File: rtl/core/b2bcd_pkg.sv
// Shared types, sizes and helpers for the binary to BCD converter.
// No dependencies; used by b2bcd_ctrl, b2bcd_datapath and the top level.
`timescale 1ns / 1ps
`default_nettype none

package b2bcd_pkg;

	// Sizing of the stores
	localparam int MaxBytes  = 16;
	localparam int BcdBytes  = 3 * MaxBytes;
	localparam int BcdW      = 8 * BcdBytes;
	localparam int IdxW      = (MaxBytes > 1) ? $clog2(MaxBytes) : 1;
	localparam int CountW    = $clog2(MaxBytes + 1);
	localparam int StepW     = CountW + 3;
	localparam int RemW      = $clog2(BcdBytes + 1);
	// Leading zero bytes are dropped this many at a time when possible
	localparam int SkipBytes = (BcdBytes >= 5) ? 4 : 1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_STEP,
		ST_SKIP,
		ST_EMIT
	} state_t;

	// Controller to datapath commands
	typedef struct packed {
		logic load;
		logic start_conv;
		logic step;
		logic finish;
		logic skip_wide;
		logic skip_one;
		logic emit;
	} cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic last_step;
		logic wide_zero;
		logic top_zero;
		logic rem_wide;
		logic rem_multi;
		logic rem_one;
	} status_t;

	// Add 3 to a BCD digit of 5 or more
	function automatic logic [3:0] add3(input logic [3:0] d);
		return (d >= 4'd5) ? (d + 4'd3) : d;
	endfunction

endpackage

`default_nettype wire

// File: rtl/core/binary_to_bcd_converter.sv
// Binary to packed BCD converter (double dabble), top level; needs b2bcd_pkg, ctrl, datapath.
// Bytes not marked last are only stored; after the last byte the held bits are shifted in
// one per step, leading zero bytes are dropped, then one result beat per cycle, with valid
// registered behind the emit. Throughput: busy stays high until the final beat is issued,
// so the next number may start while that beat is on the ports; the receiver cannot stall.
// Reset (arst_n low) empties the byte store, stops any conversion and clears valid.
`timescale 1ns / 1ps
`default_nettype none

module binary_to_bcd_converter (
	input  wire        clk,
	input  wire        arst_n,
	input  wire        start,
	output logic       busy,
	input  wire  [7:0] data_byte,
	input  wire        last_byte,
	output logic [7:0] bcd_pair,
	output logic       last_pair,
	output logic       valid
);

	b2bcd_pkg::cmd_t    cmd;
	b2bcd_pkg::status_t status;

	b2bcd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.last_byte (last_byte),
		.status    (status),
		.cmd       (cmd),
		.busy      (busy)
	);

	b2bcd_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.data_byte (data_byte),
		.status    (status),
		.bcd_pair  (bcd_pair),
		.last_pair (last_pair),
		.valid     (valid)
	);

endmodule

`default_nettype wire

// File: rtl/core/b2bcd_ctrl.sv
// Controller state machine for the binary to BCD converter.
// Depends on b2bcd_pkg; drives commands into b2bcd_datapath.
`timescale 1ns / 1ps
`default_nettype none

module b2bcd_ctrl (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   start,
	input  wire                   last_byte,
	input  b2bcd_pkg::status_t    status,
	output b2bcd_pkg::cmd_t       cmd,
	output logic                  busy
);

	b2bcd_pkg::state_t state_q;
	b2bcd_pkg::state_t state_d;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= b2bcd_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		busy    = (state_q != b2bcd_pkg::ST_IDLE);
		unique case (state_q)
			b2bcd_pkg::ST_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					if (last_byte) begin
						cmd.start_conv = 1'b1;
						state_d        = b2bcd_pkg::ST_STEP;
					end
				end
			end
			b2bcd_pkg::ST_STEP: begin
				cmd.step = 1'b1;
				if (status.last_step) begin
					cmd.finish = 1'b1;
					state_d    = b2bcd_pkg::ST_SKIP;
				end
			end
			b2bcd_pkg::ST_SKIP: begin
				// drop leading zero bytes, keep at least one
				if (status.wide_zero && status.rem_wide) begin
					cmd.skip_wide = 1'b1;
				end else if (status.top_zero && status.rem_multi) begin
					cmd.skip_one = 1'b1;
				end else begin
					cmd.emit = 1'b1;
					state_d  = status.rem_one ? b2bcd_pkg::ST_IDLE : b2bcd_pkg::ST_EMIT;
				end
			end
			b2bcd_pkg::ST_EMIT: begin
				cmd.emit = 1'b1;
				if (status.rem_one) begin
					state_d = b2bcd_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = b2bcd_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

// File: rtl/core/b2bcd_datapath.sv
// Datapath for the binary to BCD converter: byte store, shift-and-add-3
// register, step and output counters, result registers. Depends on b2bcd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module b2bcd_datapath (
	input  wire                   clk,
	input  wire                   arst_n,
	input  b2bcd_pkg::cmd_t       cmd,
	input  wire  [7:0]            data_byte,
	output b2bcd_pkg::status_t    status,
	output logic [7:0]            bcd_pair,
	output logic                  last_pair,
	output logic                  valid
);

	logic [7:0]                      bin_mem [b2bcd_pkg::MaxBytes];
	logic [b2bcd_pkg::CountW-1:0]    bytes_q;
	logic [b2bcd_pkg::StepW-1:0]     step_q;
	logic [b2bcd_pkg::BcdW-1:0]      bcd_q;
	logic [b2bcd_pkg::RemW-1:0]      rem_q;
	logic [7:0]                      pair_q;
	logic                            last_q;
	logic                            valid_q;

	logic                            room;
	logic [b2bcd_pkg::StepW-1:0]     total_steps;
	logic [b2bcd_pkg::StepW-1:0]     step_next;
	logic [7:0]                      cur_byte;
	logic                            cur_bit;
	logic [b2bcd_pkg::BcdW-1:0]      adj;

	assign room        = (bytes_q < b2bcd_pkg::CountW'(b2bcd_pkg::MaxBytes));
	assign total_steps = {bytes_q, 3'b000};
	assign step_next   = step_q + 1'b1;
	assign cur_byte    = bin_mem[step_q[3 +: b2bcd_pkg::IdxW]];
	assign cur_bit     = cur_byte[3'd7 - step_q[2:0]];

	// Add 3 to every digit of 5 or more
	always_comb begin
		for (int i = 0; i < 2 * b2bcd_pkg::BcdBytes; i++) begin
			adj[4*i +: 4] = b2bcd_pkg::add3(bcd_q[4*i +: 4]);
		end
	end

	// Store incoming bytes while there is room
	always_ff @(posedge clk) begin
		if (cmd.load && room) begin
			bin_mem[bytes_q[b2bcd_pkg::IdxW-1:0]] <= data_byte;
		end
	end

	// Byte count: advance on a stored beat, drop after conversion
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bytes_q <= '0;
		end else if (cmd.finish) begin
			bytes_q <= '0;
		end else if (cmd.load && room) begin
			bytes_q <= bytes_q + 1'b1;
		end
	end

	// Step counter over the input bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
		end else if (cmd.start_conv) begin
			step_q <= '0;
		end else if (cmd.step) begin
			step_q <= step_next;
		end
	end

	// BCD register: clear, shift-and-add-3, then shift out by bytes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bcd_q <= '0;
		end else if (cmd.start_conv) begin
			bcd_q <= '0;
		end else if (cmd.step) begin
			bcd_q <= {adj[b2bcd_pkg::BcdW-2:0], cur_bit};
		end else if (cmd.skip_wide) begin
			bcd_q <= bcd_q << (8 * b2bcd_pkg::SkipBytes);
		end else if (cmd.skip_one || cmd.emit) begin
			bcd_q <= bcd_q << 8;
		end
	end

	// Bytes of the BCD register not yet dropped or sent
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q <= '0;
		end else if (cmd.start_conv) begin
			rem_q <= b2bcd_pkg::RemW'(b2bcd_pkg::BcdBytes);
		end else if (cmd.skip_wide) begin
			rem_q <= rem_q - b2bcd_pkg::RemW'(b2bcd_pkg::SkipBytes);
		end else if (cmd.skip_one || cmd.emit) begin
			rem_q <= rem_q - 1'b1;
		end
	end

	// Result beat registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= cmd.emit;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			pair_q <= bcd_q[b2bcd_pkg::BcdW-1 -: 8];
			last_q <= (rem_q == b2bcd_pkg::RemW'(1));
		end
	end

	// Status back to the controller
	assign status.last_step = (step_next == total_steps);
	assign status.wide_zero = (bcd_q[b2bcd_pkg::BcdW-1 -: 8*b2bcd_pkg::SkipBytes] == '0);
	assign status.top_zero  = (bcd_q[b2bcd_pkg::BcdW-1 -: 8] == 8'd0);
	assign status.rem_wide  = (rem_q > b2bcd_pkg::RemW'(b2bcd_pkg::SkipBytes));
	assign status.rem_multi = (rem_q > b2bcd_pkg::RemW'(1));
	assign status.rem_one   = (rem_q == b2bcd_pkg::RemW'(1));

	assign bcd_pair  = pair_q;
	assign last_pair = last_q;
	assign valid     = valid_q;

endmodule

`default_nettype wire

// File: tb/tb_binary_to_bcd_converter.sv
// Self-checking bench for binary_to_bcd_converter: byte runs in, packed BCD beats out.
// Depends on b2bcd_pkg (store sizes) and the binary_to_bcd_converter RTL.
`timescale 1ns / 1ps

module tb_binary_to_bcd_converter;

	localparam int QuietLimit = 1500;
	localparam int TailCycles = 40;
	localparam int ReportCap  = 100;
	localparam int ItemTarget = 280;
	localparam int CalmTail   = 240;

	typedef enum int {
		FILL_RANDOM,
		FILL_ZERO,
		FILL_ONES,
		FILL_SPARSE
	} fill_t;

	typedef struct {
		logic [7:0]  data;
		logic        last;
		int unsigned rest;
		bit          wait_drain;
	} byte_item_t;

	typedef struct {
		logic [7:0] pair;
		logic       is_last;
	} bcd_beat_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       start = 1'b0;
	logic [7:0] data_byte = 8'h00;
	logic       last_byte = 1'b0;
	wire        busy;
	wire  [7:0] bcd_pair;
	wire        last_pair;
	wire        valid;

	byte_item_t  byte_queue[$];
	bcd_beat_t   bcd_beats_due[$];
	byte_item_t  next_item;
	bcd_beat_t   due_beat;
	logic [7:0]  held_bytes[b2bcd_pkg::MaxBytes];
	int          held_count = 0;
	int          rest_left = 0;
	int          bytes_taken = 0;
	int          items_total = 0;
	int          numbers_done = 0;
	int          dropped_bytes = 0;
	int          beats_checked = 0;
	int          mismatches = 0;
	int          quiet_cycles = 0;
	bit          idling_on = 1'b1;

	binary_to_bcd_converter uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.data_byte (data_byte),
		.last_byte (last_byte),
		.bcd_pair  (bcd_pair),
		.last_pair (last_pair),
		.valid     (valid)
	);

	always #6 clk = ~clk;

	// Hold the byte; on the last byte run double dabble and queue the expected BCD beats
	task automatic track_byte(input logic [7:0] data, input logic last);
		logic [b2bcd_pkg::BcdW-1:0] bcd;
		logic [3:0]      nib;
		logic            in_bit;
		int              lead;
		bcd_beat_t       beat;
		if (held_count < b2bcd_pkg::MaxBytes) begin
			held_bytes[held_count] = data;
			held_count++;
		end else begin
			dropped_bytes++;
		end
		if (last) begin
			bcd = '0;
			for (int s = 0; s < held_count * 8; s++) begin
				in_bit = held_bytes[s / 8][7 - (s % 8)];
				for (int d = 0; d < 2 * b2bcd_pkg::BcdBytes; d++) begin
					nib = bcd[4*d +: 4];
					if (nib >= 4'd5)
						bcd[4*d +: 4] = nib + 4'd3;
				end
				bcd = {bcd[b2bcd_pkg::BcdW-2:0], in_bit};
			end
			// drop leading zero bytes, keep at least one
			lead = 0;
			while (lead + 1 < b2bcd_pkg::BcdBytes &&
			    bcd[b2bcd_pkg::BcdW-1-8*lead -: 8] == 8'h00)
				lead++;
			for (int k = lead; k < b2bcd_pkg::BcdBytes; k++) begin
				beat.pair    = bcd[b2bcd_pkg::BcdW-1-8*k -: 8];
				beat.is_last = (k == b2bcd_pkg::BcdBytes - 1);
				bcd_beats_due.push_back(beat);
			end
			held_count = 0;
			numbers_done++;
		end
	endtask

	task automatic add_byte(input logic [7:0] data, input logic last, input bit drain);
		byte_item_t item;
		item.data       = data;
		item.last       = last;
		item.wait_drain = drain;
		item.rest       = (idling_on && $urandom_range(0, 2) == 0) ? $urandom_range(1, 7) : 0;
		byte_queue.push_back(item);
	endtask

	task automatic add_number(input int len, input fill_t fill, input bit drain);
		logic [7:0] value;
		for (int i = 0; i < len; i++) begin
			case (fill)
				FILL_ZERO:   value = 8'h00;
				FILL_ONES:   value = 8'hFF;
				FILL_SPARSE: value = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'h00;
				default:     value = 8'($urandom);
			endcase
			add_byte(value, i == len - 1, drain && i == 0);
		end
	endtask

	// Present queued bytes on start/busy; idle with noise on the data lines between beats
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start     <= 1'b0;
			data_byte <= 8'h00;
			last_byte <= 1'b0;
			rest_left <= 0;
		end else begin
			if (start && !busy) begin
				track_byte(data_byte, last_byte);
				bytes_taken++;
			end
			if (start && busy) begin
				// hold the beat until the block takes it
			end else if (rest_left > 0 || byte_queue.size() == 0 ||
			    (byte_queue[0].wait_drain && bcd_beats_due.size() != 0)) begin
				if (rest_left > 0)
					rest_left <= rest_left - 1;
				start     <= 1'b0;
				data_byte <= 8'($urandom);
				last_byte <= 1'($urandom);
			end else begin
				next_item = byte_queue.pop_front();
				start     <= 1'b1;
				data_byte <= next_item.data;
				last_byte <= next_item.last;
				rest_left <= next_item.rest;
			end
		end
	end

	// Check each result beat against the oldest expected one
	always @(posedge clk) begin
		if (arst_n && valid) begin
			if (bcd_beats_due.size() == 0) begin
				mismatches++;
				if (mismatches <= ReportCap)
					$display("%0t: expected no beat, actual bcd_pair %02h last_pair %0b",
					    $time, bcd_pair, last_pair);
			end else begin
				due_beat = bcd_beats_due.pop_front();
				beats_checked++;
				if (bcd_pair !== due_beat.pair) begin
					mismatches++;
					if (mismatches <= ReportCap)
						$display("%0t: bcd_pair expected %02h actual %02h",
						    $time, due_beat.pair, bcd_pair);
				end
				if (last_pair !== due_beat.is_last) begin
					mismatches++;
					if (mismatches <= ReportCap)
						$display("%0t: last_pair expected %0b actual %0b",
						    $time, due_beat.is_last, last_pair);
				end
			end
		end
	end

	// Count cycles in which no beat moves on either side
	always @(posedge clk) begin
		if ((start && !busy) || valid)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
	end

	initial begin
		// directed: zero, extremes, a lone top bit, leading zero bytes, full-width maximum
		add_byte(8'h00, 1'b1, 1'b0);
		add_byte(8'hFF, 1'b1, 1'b0);
		add_byte(8'h80, 1'b1, 1'b0);
		add_number(2, FILL_ZERO, 1'b0);
		add_byte(8'h00, 1'b0, 1'b0);
		add_byte(8'h05, 1'b1, 1'b0);
		add_number(b2bcd_pkg::MaxBytes, FILL_ONES, 1'b0);

		// overflow: extra bytes past the store, once with the dropped byte marked last
		add_number(b2bcd_pkg::MaxBytes + 1, FILL_RANDOM, 1'b1);
		add_number(b2bcd_pkg::MaxBytes + 4, FILL_RANDOM, 1'b0);

		// random numbers: mostly short, some long, a few past the store
		while (byte_queue.size() < ItemTarget) begin
			int    pick;
			int    len;
			fill_t fill;
			bit    drain;
			if ($urandom_range(0, 3) == 0)
				idling_on = !idling_on;
			if (byte_queue.size() >= CalmTail)
				idling_on = 1'b0;
			pick = $urandom_range(0, 19);
			if (pick == 0)
				len = $urandom_range(b2bcd_pkg::MaxBytes + 1, b2bcd_pkg::MaxBytes + 5);
			else if (pick <= 3)
				len = $urandom_range(5, b2bcd_pkg::MaxBytes);
			else
				len = $urandom_range(1, 4);
			case ($urandom_range(0, 9))
				0:       fill = FILL_ZERO;
				1:       fill = FILL_ONES;
				2:       fill = FILL_SPARSE;
				default: fill = FILL_RANDOM;
			endcase
			drain = (byte_queue.size() < CalmTail) && ($urandom_range(0, 9) == 0);
			add_number(len, fill, drain);
		end
		items_total = byte_queue.size();

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		while (!(bytes_taken == items_total && bcd_beats_due.size() == 0) &&
		    quiet_cycles < QuietLimit)
			@(negedge clk);

		if (quiet_cycles >= QuietLimit) begin
			$display("%0t: no beat moved for %0d cycles, %0d of %0d bytes taken, %0d beats due",
			    $time, QuietLimit, bytes_taken, items_total, bcd_beats_due.size());
			$display("Regression FAIL");
		end else begin
			repeat (TailCycles) @(negedge clk);
			$display("Converted %0d numbers from %0d input bytes (%0d past the store).",
			    numbers_done, bytes_taken, dropped_bytes);
			$display("Checked %0d BCD beats, %0d mismatches.", beats_checked, mismatches);
			if (mismatches == 0)
				$display("Regression PASS");
			else
				$display("Regression FAIL");
		end
		$finish;
	end

endmodule
